@@ src/svp_pkg.sv @@
package svp_pkg;

	// Field and register widths.
	localparam int TgtW     = 24;
	localparam int VelW     = 16;
	localparam int AccW     = 20;
	localparam int TimeW    = 32;
	localparam int EncW     = 32;
	localparam int DrvW     = 17;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 24;

	// Register indexes on the configuration port.
	localparam logic [CfgIdxW-1:0] REG_TARGET_DISTANCE = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_VELOCITY    = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_ACCEL_LIMIT     = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_MIN_SPEED       = 2'd3;

	// Register reset values.
	localparam logic [TgtW-1:0] RST_TARGET_DISTANCE = 24'd0;
	localparam logic [VelW-1:0] RST_MAX_VELOCITY    = 16'd12800;
	localparam logic [AccW-1:0] RST_ACCEL_LIMIT     = 20'd25600;
	localparam logic [VelW-1:0] RST_MIN_SPEED       = 16'd1257;

	// Shared unit sizes.
	localparam int MulAW = 32;
	localparam int MulBW = 21;
	localparam int ProdW = MulAW + MulBW;
	localparam int StepW = 52;
	localparam int SubW  = 45;

	// Division of the speed step by one million. While the speed ramps the step stays
	// below 2^36. Six low bits are dropped first, which leaves a divisor of 15625, and
	// the reciprocal floor(2^34 / 15625) gives the quotient or one less; a compare
	// against the product of the quotient and one million settles it.
	localparam int DivW     = 36;
	localparam int RcpShift = 6;
	localparam int RcpFrac  = 34;

	// Integer square root of 2 * max_accel * remaining, two radicand bits per cycle.
	localparam int RadW      = 44;
	localparam int RootW     = 22;
	localparam int SqrtSteps = 22;
	localparam int IterW     = 5;

	// Distance arithmetic.
	localparam int TravW = 34;
	localparam int RemW  = 23;

	localparam logic [19:0]      US_PER_S    = 20'd1000000;
	localparam logic [MulBW-1:0] US_RECIP    = 21'd1099511;
	localparam logic [17:0]      TICK_SCALE  = 18'd237914;
	localparam logic [15:0]      ROUND_HALF  = 16'd32768;
	localparam logic [9:0]       OFFSET_DIST = 10'd768;
	localparam logic [7:0]       FINISH_DIST = 8'd128;

	localparam logic [RadW-1:0] SQRT_BIT_TOP  = RadW'(1) << (RadW - 2);

	typedef struct packed {
		logic             mul_en;
		logic [MulAW-1:0] mul_a;
		logic [MulBW-1:0] mul_b;
		logic [SubW-1:0]  sub_a;
		logic [SubW-1:0]  sub_b;
	} alu_req_t;

	typedef struct packed {
		logic [ProdW-1:0] prod;
		logic [SubW-1:0]  diff;
		logic             ge;
	} alu_rsp_t;

endpackage

@@ src/svp_ifs.sv @@
interface svp_in_if import svp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [TimeW-1:0]       time_us;
	logic signed [EncW-1:0] encoder_count;

	modport source (output valid, output time_us, output encoder_count, input ready);
	modport sink (input valid, input time_us, input encoder_count, output ready);
endinterface

interface svp_out_if import svp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   finished;
	logic signed [DrvW-1:0] drive_velocity;

	modport source (output valid, output finished, output drive_velocity, input ready);
	modport sink (input valid, input finished, input drive_velocity, output ready);
endinterface

@@ src/svp_alu.sv @@
module svp_alu import svp_pkg::*; (
	input  logic     clk,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	// The product is registered so that no result feeds a second multiply in one cycle.
	logic [ProdW-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.mul_en) begin
			prod_q <= ProdW'(req.mul_a) * ProdW'(req.mul_b);
		end
	end

	assign rsp.prod = prod_q;
	assign rsp.diff = req.sub_a - req.sub_b;
	assign rsp.ge   = (req.sub_a >= req.sub_b);

endmodule

@@ src/straight_drive_velocity_profiler.sv @@
// Channel   Role   Word contents
// sample    sink   time_us (32 b unsigned), encoder_count (32 b signed)
// result    source finished (1 b), drive_velocity (17 b signed)
// cfg_*     write  cfg_index selects one of four registers, cfg_data holds its value
//
// After it accepts a sample word, the block is not ready again until it has worked the
// word through and loaded its result, and loading waits while the result register is
// held by a stalled sink. The 22 square root steps share one subtractor and all the
// products share one multiplier; a ramping speed adds the states that divide the step
// by one million by reciprocal multiplication, correct the quotient and update the speed.
// The asynchronous reset clears the profile state, the control and restores the
// register defaults. A finished result is held in its own register, so a new sample is
// taken while that result still waits.
module straight_drive_velocity_profiler import svp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	svp_in_if.sink              sample,
	svp_out_if.source           result
);

	// Sequencer states.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MSTEP = 4'd1;
	localparam logic [3:0] S_MDIFF = 4'd2;
	localparam logic [3:0] S_CMP   = 4'd3;
	localparam logic [3:0] S_RCP   = 4'd4;
	localparam logic [3:0] S_QUO   = 4'd5;
	localparam logic [3:0] S_QMUL  = 4'd6;
	localparam logic [3:0] S_QFIX  = 4'd7;
	localparam logic [3:0] S_ADJ   = 4'd8;
	localparam logic [3:0] S_MTRAV = 4'd9;
	localparam logic [3:0] S_REM   = 4'd10;
	localparam logic [3:0] S_MCAP  = 4'd11;
	localparam logic [3:0] S_SQLD  = 4'd12;
	localparam logic [3:0] S_SQRT  = 4'd13;
	localparam logic [3:0] S_OUT   = 4'd14;

	// Configuration registers.
	logic signed [TgtW-1:0] tgt_q;
	logic [VelW-1:0]        vmax_q;
	logic [AccW-1:0]        amax_q;
	logic [VelW-1:0]        vmin_q;

	// Profile state carried from one sample to the next.
	logic [VelW-1:0]  last_spd_q;
	logic [TimeW-1:0] last_time_q;

	logic [3:0]       state_q;
	logic [IterW-1:0] iter_q;

	// Datapath registers.
	logic [TimeW-1:0] dt_q;
	logic [EncW-1:0]  mag_enc_q;
	logic [StepW-1:0] step_q;
	logic             dir_up_q;
	logic [VelW-1:0]  diff_q;
	logic [VelW-1:0]  quo_q;
	logic [VelW-1:0]  spd_q;
	logic [RemW-1:0]  rem_q;
	logic             done_q;
	logic [RadW-1:0]  rad_q;
	logic [SubW-1:0]  root_q;
	logic [RadW-1:0]  bit_q;

	logic                   out_valid_q;
	logic                   out_fin_q;
	logic signed [DrvW-1:0] out_vel_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	svp_alu u_alu (
		.clk (clk),
		.req (alu_req),
		.rsp (alu_rsp)
	);

	logic                   accept;
	logic                   out_free;
	logic                   dir_up_c;
	logic [VelW-1:0]        diff_c;
	logic                   quo_low;
	logic [TgtW-1:0]        mag_tgt;
	logic [ProdW-1:0]       trav_sum;
	logic [TravW-1:0]       trav;
	logic signed [TravW+1:0] rem_full;
	logic                   ramp;
	logic [RootW-1:0]       cap;
	logic [VelW-1:0]        spd_capped;
	logic [VelW-1:0]        spd_final;
	logic signed [DrvW-1:0] vel_signed;

	assign accept   = sample.valid && sample.ready;
	assign out_free = !out_valid_q || result.ready;

	assign sample.ready          = (state_q == S_IDLE);
	assign result.valid          = out_valid_q;
	assign result.finished       = out_fin_q;
	assign result.drive_velocity = out_vel_q;

	// Distance to the cruise limit and the direction the speed has to move.
	assign dir_up_c = (vmax_q > last_spd_q);
	assign diff_c   = dir_up_c ? (vmax_q - last_spd_q) : (last_spd_q - vmax_q);

	// The speed ramps only when the full gap cannot be closed in this tick.
	assign ramp = (alu_rsp.prod > {1'b0, step_q});

	// The reciprocal quotient is one short when another million still fits in the step.
	assign quo_low = (ProdW'(step_q) >= alu_rsp.prod + ProdW'(US_PER_S));

	// Travelled distance rounded to nearest, then what is left after the stop offset.
	assign mag_tgt  = tgt_q[TgtW-1] ? TgtW'(-tgt_q) : TgtW'(tgt_q);
	assign trav_sum = alu_rsp.prod + ProdW'(ROUND_HALF);
	assign trav     = trav_sum[TravW+15:16];
	assign rem_full = $signed({12'b0, mag_tgt}) - $signed({2'b0, trav})
		- $signed((TravW+2)'(OFFSET_DIST));

	// Cap by the braking curve, then lift to the feed-forward floor.
	assign cap        = root_q[RootW-1:0];
	assign spd_capped = ({6'b0, spd_q} > cap) ? cap[VelW-1:0] : spd_q;
	assign spd_final  = (spd_capped < vmin_q) ? vmin_q : spd_capped;
	assign vel_signed = (tgt_q > 0) ? $signed({1'b0, spd_final})
		: -$signed({1'b0, spd_final});

	// Operand selection for the shared multiplier and subtractor.
	always_comb begin
		alu_req = '0;
		case (state_q)
			S_MSTEP: begin
				alu_req.mul_en = 1'b1;
				alu_req.mul_a  = dt_q;
				alu_req.mul_b  = MulBW'(amax_q);
			end
			S_MDIFF: begin
				alu_req.mul_en = 1'b1;
				alu_req.mul_a  = MulAW'(diff_c);
				alu_req.mul_b  = MulBW'(US_PER_S);
			end
			S_RCP: begin
				alu_req.mul_en = 1'b1;
				alu_req.mul_a  = MulAW'(step_q[DivW-1:RcpShift]);
				alu_req.mul_b  = US_RECIP;
			end
			S_QMUL: begin
				alu_req.mul_en = 1'b1;
				alu_req.mul_a  = MulAW'(quo_q);
				alu_req.mul_b  = MulBW'(US_PER_S);
			end
			S_MTRAV: begin
				alu_req.mul_en = 1'b1;
				alu_req.mul_a  = mag_enc_q;
				alu_req.mul_b  = MulBW'(TICK_SCALE);
			end
			S_MCAP: begin
				alu_req.mul_en = 1'b1;
				alu_req.mul_a  = MulAW'(rem_q);
				alu_req.mul_b  = {amax_q, 1'b0};
			end
			S_SQRT: begin
				alu_req.sub_a = SubW'(rad_q);
				alu_req.sub_b = root_q + SubW'(bit_q);
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	// Control, configuration and profile state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iter_q      <= '0;
			tgt_q       <= RST_TARGET_DISTANCE;
			vmax_q      <= RST_MAX_VELOCITY;
			amax_q      <= RST_ACCEL_LIMIT;
			vmin_q      <= RST_MIN_SPEED;
			last_spd_q  <= '0;
			last_time_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TARGET_DISTANCE: tgt_q  <= cfg_data[TgtW-1:0];
					REG_MAX_VELOCITY:    vmax_q <= cfg_data[VelW-1:0];
					REG_ACCEL_LIMIT:     amax_q <= cfg_data[AccW-1:0];
					REG_MIN_SPEED:       vmin_q <= cfg_data[VelW-1:0];
					default: begin
					end
				endcase
			end

			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_time_q <= sample.time_us;
						state_q     <= S_MSTEP;
					end
				end
				S_MSTEP: state_q <= S_MDIFF;
				S_MDIFF: state_q <= S_CMP;
				S_CMP: begin
					if (ramp) begin
						state_q <= S_RCP;
					end else begin
						state_q <= S_MTRAV;
					end
				end
				S_RCP:   state_q <= S_QUO;
				S_QUO:   state_q <= S_QMUL;
				S_QMUL:  state_q <= S_QFIX;
				S_QFIX:  state_q <= S_ADJ;
				S_ADJ:   state_q <= S_MTRAV;
				S_MTRAV: state_q <= S_REM;
				S_REM:   state_q <= S_MCAP;
				S_MCAP:  state_q <= S_SQLD;
				S_SQLD: begin
					iter_q  <= IterW'(SqrtSteps - 1);
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (iter_q == '0) begin
						state_q <= S_OUT;
					end else begin
						iter_q <= iter_q - 1'b1;
					end
				end
				S_OUT: begin
					if (out_free) begin
						last_spd_q <= spd_final;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					dt_q      <= sample.time_us - last_time_q;
					mag_enc_q <= sample.encoder_count[EncW-1]
						? EncW'(-sample.encoder_count) : EncW'(sample.encoder_count);
				end
			end
			S_MDIFF: begin
				step_q   <= alu_rsp.prod[StepW-1:0];
				dir_up_q <= dir_up_c;
				diff_q   <= diff_c;
			end
			S_CMP: begin
				spd_q <= vmax_q;
			end
			S_QUO: begin
				quo_q <= alu_rsp.prod[RcpFrac+VelW-1:RcpFrac];
			end
			S_QFIX: begin
				quo_q <= quo_q + VelW'(quo_low);
			end
			S_ADJ: begin
				spd_q <= dir_up_q ? (last_spd_q + quo_q) : (last_spd_q - quo_q);
			end
			S_REM: begin
				if (rem_full < 0) begin
					rem_q <= '0;
				end else begin
					rem_q <= rem_full[RemW-1:0];
				end
				done_q <= (rem_full < $signed((TravW+2)'(FINISH_DIST)));
			end
			S_SQLD: begin
				rad_q  <= alu_rsp.prod[RadW-1:0];
				root_q <= '0;
				bit_q  <= SQRT_BIT_TOP;
			end
			S_SQRT: begin
				if (alu_rsp.ge) begin
					rad_q  <= alu_rsp.diff[RadW-1:0];
					root_q <= (root_q >> 1) + SubW'(bit_q);
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_OUT: begin
				if (out_free) begin
					out_fin_q <= done_q;
					out_vel_q <= done_q ? '0 : vel_signed;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("sample taken while a word is in work");

	a_result_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && result.valid && !result.ready |=> (state_q == S_OUT))
		else $error("new result loaded over a stalled one");

	a_ramp_below_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADJ) |-> (quo_q < diff_q))
		else $error("speed step reaches past the cruise limit");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (root_q[SubW-1:RootW] == '0))
		else $error("square root out of range");

	a_finished_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.finished |-> (result.drive_velocity == '0))
		else $error("finished result carries a velocity");
`endif

endmodule

@@ sim/tb_straight_drive_velocity_profiler.sv @@
`timescale 1ns / 100ps

module tb_straight_drive_velocity_profiler;
	import svp_pkg::*;

	// Physical constants of the drive, in the block's fixed point units.
	localparam longint unsigned WHEEL_SCALE_Q16 = 237914;  // 1/256 inch per tick, Q16
	localparam longint unsigned HALF_LSB_Q16    = 32768;
	localparam longint          STOP_OFFSET     = 768;     // three inches
	localparam longint          DONE_MARGIN     = 128;     // half an inch
	localparam longint unsigned MICROS_PER_SEC  = 1000000;

	// This settles any straggler word before the final check.
	localparam int SETTLE_CYCLES    = 60;
	// One long receiver hold plus the slowest sender gap fit well inside this.
	localparam int STALL_LIMIT      = 5000;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam int READY_PCTS [4]   = '{100, 75, 40, 10};

	typedef struct packed {
		logic [TimeW-1:0]       time_us;
		logic signed [EncW-1:0] encoder_count;
	} tick_word_t;

	typedef struct packed {
		logic                   finished;
		logic signed [DrvW-1:0] drive_velocity;
	} command_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	svp_in_if  sample_bus ();
	svp_out_if result_bus ();

	straight_drive_velocity_profiler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_bus),
		.result    (result_bus)
	);

	// Our own copy of the registers and of the profile state, as they stand after reset.
	logic signed [TgtW-1:0] target_dist = RST_TARGET_DISTANCE;
	logic [VelW-1:0]        vel_limit   = RST_MAX_VELOCITY;
	logic [AccW-1:0]        accel_limit = RST_ACCEL_LIMIT;
	logic [VelW-1:0]        speed_floor = RST_MIN_SPEED;
	logic [VelW-1:0]        prev_speed  = '0;
	logic [TimeW-1:0]       prev_time   = '0;

	tick_word_t    pending_ticks[$];
	command_word_t expected_commands[$];

	logic sample_fire = 1'b0;
	int   mismatch_count = 0;
	int   results_seen = 0;
	int   idle_cycles = 0;

	// Sender pacing.
	int burst_left = 0;
	int gap_left = 0;

	// Receiver pacing.
	int pattern_left = 0;
	int ready_pct = 100;
	int hold_left = 0;
	int long_holds = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Exact integer square root, found one result bit at a time from the top.
	function automatic longint unsigned root_floor(longint unsigned radicand);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= radicand)
				root = trial;
		end
		return root;
	endfunction

	// Register writes mask the data to the width of the selected register.
	function automatic void apply_register(logic [CfgIdxW-1:0] index,
			logic [CfgDataW-1:0] data);
		case (index)
			REG_TARGET_DISTANCE: target_dist = data[TgtW-1:0];
			REG_MAX_VELOCITY:    vel_limit = data[VelW-1:0];
			REG_ACCEL_LIMIT:     accel_limit = data[AccW-1:0];
			REG_MIN_SPEED:       speed_floor = data[VelW-1:0];
			default: ;
		endcase
	endfunction

	// Works out the command for one control tick and advances the profile state.
	function automatic command_word_t next_drive_command(logic [TimeW-1:0] now,
			logic signed [EncW-1:0] ticks);
		logic [TimeW-1:0] dt;
		longint unsigned  speed;
		longint unsigned  accel_budget;
		longint unsigned  enc_mag;
		longint unsigned  travelled;
		longint unsigned  tgt_mag;
		longint unsigned  cap;
		longint           remaining;
		command_word_t    cmd;

		// The timer wraps, so the difference is taken modulo 2^32.
		dt = now - prev_time;
		accel_budget = 64'(accel_limit) * 64'(dt);
		speed = 64'(vel_limit);

		// The speed only moves part way when the full change would exceed the budget.
		// Comparing by multiplication keeps the speed put when dt is zero.
		if (vel_limit < prev_speed) begin
			if (64'(prev_speed - vel_limit) * MICROS_PER_SEC > accel_budget)
				speed = 64'(prev_speed) - accel_budget / MICROS_PER_SEC;
		end else if (vel_limit > prev_speed) begin
			if (64'(vel_limit - prev_speed) * MICROS_PER_SEC > accel_budget)
				speed = 64'(prev_speed) + accel_budget / MICROS_PER_SEC;
		end

		enc_mag = (ticks < 0) ? 64'(-longint'(ticks)) : 64'(ticks);
		travelled = (enc_mag * WHEEL_SCALE_Q16 + HALF_LSB_Q16) >> 16;
		tgt_mag = (target_dist < 0) ? 64'(-longint'(target_dist)) : 64'(target_dist);
		remaining = longint'(tgt_mag) - longint'(travelled) - STOP_OFFSET;
		if (remaining < 0)
			remaining = 0;

		cap = root_floor(64'(accel_limit) * 64'(remaining) * 2);
		if (speed > cap)
			speed = cap;
		if (speed < 64'(speed_floor))
			speed = 64'(speed_floor);

		// The state moves on even when the drive has finished.
		prev_speed = speed[VelW-1:0];
		prev_time = now;

		cmd.finished = (remaining < DONE_MARGIN);
		if (cmd.finished)
			cmd.drive_velocity = '0;
		else if (target_dist > 0)
			cmd.drive_velocity = DrvW'(speed);
		else
			cmd.drive_velocity = DrvW'(64'd0 - speed);
		return cmd;
	endfunction

	// Sender: offers the oldest pending word in bursts with random gaps between them.
	// A word stays on the bus untouched until the block has taken it.
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_bus.valid <= 1'b0;
		end else begin
			if (sample_fire)
				void'(pending_ticks.pop_front());
			if (!sample_bus.valid || sample_fire) begin
				if (gap_left != 0) begin
					gap_left--;
					sample_bus.valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					sample_bus.valid <= 1'b1;
					sample_bus.time_us <= pending_ticks[0].time_us;
					sample_bus.encoder_count <= pending_ticks[0].encoder_count;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 16);
					burst_left--;
					// A quarter of the bursts run straight into the next one.
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
				end else begin
					sample_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: the ready rate is redrawn from READY_PCTS each time its pattern runs out.
	// Twice in the run it also holds off for a long stretch while the sender is offering,
	// so that the result register fills and the block has to stall its sample input.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (pattern_left == 0) begin
				pattern_left = 256;
				ready_pct = READY_PCTS[$urandom_range(0, 3)];
			end
			pattern_left--;
			if (long_holds < 2 && hold_left == 0 && sample_bus.valid
					&& results_seen >= 80 + 180 * long_holds) begin
				long_holds++;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(1, 100) <= ready_pct);
			end
		end
	end

	// Monitor: mirrors register writes, predicts each accepted sample word and checks
	// each accepted result word against the oldest prediction. It also keeps the
	// watchdog, which ends the run when nothing moves for too long.
	always @(posedge clk) begin
		command_word_t due;
		logic          took_sample;
		logic          took_result;

		took_sample = sample_bus.valid && sample_bus.ready;
		took_result = result_bus.valid && result_bus.ready;
		if (!arst_n) begin
			sample_fire <= 1'b0;
		end else begin
			sample_fire <= took_sample;
			if (cfg_we)
				apply_register(cfg_index, cfg_data);

			if (took_result) begin
				results_seen++;
				if (expected_commands.size() == 0) begin
					$error("unexpected result word: finished %0d, drive_velocity %0d",
						result_bus.finished, result_bus.drive_velocity);
					mismatch_count++;
				end else begin
					due = expected_commands.pop_front();
					if (result_bus.finished !== due.finished) begin
						$error("finished: expected %0d, actual %0d",
							due.finished, result_bus.finished);
						mismatch_count++;
					end
					if (result_bus.drive_velocity !== due.drive_velocity) begin
						$error("drive_velocity: expected %0d, actual %0d",
							due.drive_velocity, result_bus.drive_velocity);
						mismatch_count++;
					end
				end
			end

			if (took_sample)
				expected_commands.push_back(next_drive_command(sample_bus.time_us,
					sample_bus.encoder_count));

			if (took_sample || took_result || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	function automatic void queue_tick(logic [TimeW-1:0] stamp, logic signed [EncW-1:0] ticks);
		pending_ticks.push_back('{time_us: stamp, encoder_count: ticks});
	endfunction

	// Waits until every queued word has been taken and every command has come back.
	// The block makes exactly one command per word, so it is idle from then on.
	task automatic drain_profile();
		while (pending_ticks.size() != 0 || expected_commands.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(logic [CfgIdxW-1:0] index, logic [CfgDataW-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Writes all four registers. The unused upper data bits of the narrower registers
	// carry random junk, which the block has to mask off.
	task automatic set_profile(logic signed [TgtW-1:0] tgt_dist, logic [VelW-1:0] vmax,
			logic [AccW-1:0] amax, logic [VelW-1:0] vmin);
		write_register(REG_TARGET_DISTANCE, CfgDataW'(tgt_dist));
		write_register(REG_MAX_VELOCITY, CfgDataW'({$urandom(), vmax}));
		write_register(REG_ACCEL_LIMIT, CfgDataW'({$urandom(), amax}));
		write_register(REG_MIN_SPEED, CfgDataW'({$urandom(), vmin}));
	endtask

	initial begin
		logic [TimeW-1:0]       clock_us;
		logic signed [EncW-1:0] odo;
		int unsigned            dist_mag;
		int unsigned            stride;
		logic                   reverse;
		logic signed [TgtW-1:0] drive_dist;

		sample_bus.valid = 1'b0;
		sample_bus.time_us = '0;
		sample_bus.encoder_count = '0;
		result_bus.ready = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// With the reset settings the target is zero, so every tick is finished.
		// The very first tick also measures dt from time zero.
		queue_tick(32'd0, 32'sd0);
		queue_tick(32'd4000, 32'sd0);
		drain_profile();

		// Largest positive target with the widest limits: ramp, a zero dt while
		// still ramping, a huge dt that reaches the cruise limit, a zero dt at the
		// limit, a timer wrap, and both encoder extremes, which finish at once.
		set_profile(24'sh7FFFFF, 16'hFFFF, 20'hFFFFF, 16'h0000);
		queue_tick(32'd10000, 32'sd0);
		queue_tick(32'd10000, 32'sd0);
		queue_tick(32'hFFFFFF00, 32'sd50);
		queue_tick(32'hFFFFFF00, 32'sd60);
		queue_tick(32'h00000100, -32'sd70);
		queue_tick(32'h00000200, 32'sh7FFFFFFF);
		queue_tick(32'h00000300, 32'sh80000000);
		drain_profile();

		// Most negative target with all limits at zero and the floor at its top:
		// the cap collapses and the floor gives the most negative velocity.
		set_profile(24'sh800000, 16'h0000, 20'h00000, 16'hFFFF);
		queue_tick(32'h00001000, 32'sd0);
		queue_tick(32'h00002000, -32'sd5);
		queue_tick(32'h00002000, 32'sd5);
		drain_profile();

		// A short target right at the half inch margin, decelerating from full speed.
		// Zero and one tick leave at least half an inch; two ticks leave less.
		set_profile(24'sd900, 16'd12800, 20'd25600, 16'd1257);
		queue_tick(32'h000A0000, 32'sd0);
		queue_tick(32'h000B0000, 32'sd1);
		queue_tick(32'h000C0000, 32'sd2);
		queue_tick(32'h000D0000, -32'sd1);
		queue_tick(32'h000E0000, -32'sd2);
		drain_profile();

		// Random drives. Each one writes fresh settings, then feeds ticks with a
		// rising timestamp and an encoder count that moves toward the target, so
		// the profile ramps, cruises, brakes and finishes. One tick in ten is noise.
		clock_us = 32'd0;
		for (int p = 0; p < 8; p++) begin
			reverse = $urandom_range(0, 1);
			dist_mag = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8388607)
				: $urandom_range(800, 60000);
			drive_dist = reverse ? TgtW'(-int'(dist_mag)) : TgtW'(dist_mag);
			set_profile(drive_dist,
				($urandom_range(0, 5) == 0) ? VelW'($urandom())
					: VelW'($urandom_range(2000, 20000)),
				($urandom_range(0, 5) == 0) ? AccW'($urandom())
					: AccW'($urandom_range(5000, 150000)),
				($urandom_range(0, 5) == 0) ? VelW'($urandom())
					: VelW'($urandom_range(0, 3000)));

			// Every third drive starts just below the timer wrap.
			if (p % 3 == 2)
				clock_us = 32'hFFFF0000 + $urandom_range(0, 60000);
			odo = '0;
			// Sized so that a drive usually reaches its target within the run.
			stride = dist_mag / 80 + 1;
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					queue_tick($urandom(), $urandom());
				end else begin
					clock_us += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(500, 20000);
					if (reverse)
						odo -= $urandom_range(0, stride);
					else
						odo += $urandom_range(0, stride);
					queue_tick(clock_us, odo);
				end
			end
			drain_profile();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_commands.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/svp_pkg.sv
src/svp_ifs.sv
src/svp_alu.sv
src/straight_drive_velocity_profiler.sv
sim/tb_straight_drive_velocity_profiler.sv
